// ===== rtl/core/mwm_pkg.sv =====
package mwm_pkg;

  // Field and datapath widths
  localparam int unsigned SPD_W   = 8;   // command speed fields
  localparam int unsigned WHL_W   = 10;  // mixed wheel speed, -300..300
  localparam int unsigned MAG_W   = 9;   // wheel magnitude, 0..300
  localparam int unsigned NUM_W   = 15;  // magnitude * 100, 0..30000
  localparam int unsigned QUO_W   = 7;   // scaled magnitude, 0..100
  localparam int unsigned PER_W   = 16;  // pwm period register
  localparam int unsigned MSK_W   = 4;   // invert mask register
  localparam int unsigned PULSE_W = 16;  // pulse width field
  localparam int unsigned WHEELS  = 4;

  // Wheel slots, also the invert mask bit order
  localparam int unsigned WHL_FL = 0;
  localparam int unsigned WHL_FR = 1;
  localparam int unsigned WHL_RL = 2;
  localparam int unsigned WHL_RR = 3;

  localparam int unsigned FULL_SCALE     = 100;
  localparam int unsigned PULSE_BITS_DEF = 16;

  localparam logic signed [WHL_W-1:0] PCT_MAX = 10'sd100;
  localparam logic signed [WHL_W-1:0] PCT_MIN = -10'sd100;

  // Divide by 100 as (x >> 2) / 25; y * ceil(2^26 / 25) >> 26 is exact for y < 2^21
  localparam int unsigned PROD_W      = PER_W + QUO_W;   // period * quotient
  localparam int unsigned Y_W         = PROD_W - 2;
  localparam int unsigned YL_W        = 10;
  localparam int unsigned YH_W        = Y_W - YL_W;
  localparam int unsigned RECIP_W     = 22;
  localparam int unsigned RECIP_SHIFT = 26;
  localparam logic [RECIP_W-1:0] RECIP_25 = 22'd2684355;
  localparam int unsigned PH_W  = YH_W + RECIP_W;
  localparam int unsigned PL_W  = YL_W + RECIP_W;
  localparam int unsigned SUM_W = PH_W + YL_W;

  // Configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic [0:0] REG_PWM_PERIOD  = 1'd0;
  localparam logic [0:0] REG_INVERT_MASK = 1'd1;
  localparam logic [PER_W-1:0] PERIOD_RST = 16'd20000;
  localparam logic [MSK_W-1:0] INVERT_RST = 4'd5;

  typedef struct packed {
    logic [PER_W-1:0] period;
    logic [MSK_W-1:0] invert;
  } cfg_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } whl_t;

  typedef whl_t [WHEELS-1:0] whl_vec_t;

  // One wheel inside the divider: partial remainder and quotient bits
  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } divw_t;

  typedef struct packed {
    divw_t [WHEELS-1:0] w;
    logic [MAG_W-1:0]   den;
  } div_t;

  // Clamp a command component to -100..100, widened for mixing
  function automatic logic signed [WHL_W-1:0] sat_pct(input logic signed [SPD_W-1:0] v);
    logic signed [WHL_W-1:0] x;
    x = WHL_W'(v);
    if (x > PCT_MAX) begin
      return PCT_MAX;
    end else if (x < PCT_MIN) begin
      return PCT_MIN;
    end
    return x;
  endfunction

endpackage

// ===== rtl/core/mwm_if.sv =====
// Drive command channel
interface mwm_cmd_if;
  logic                                valid;
  logic                                ready;
  logic signed [mwm_pkg::SPD_W-1:0]    speed_forward;
  logic signed [mwm_pkg::SPD_W-1:0]    speed_strafe;
  logic signed [mwm_pkg::SPD_W-1:0]    speed_turn;

  modport source (output valid, speed_forward, speed_strafe, speed_turn, input ready);
  modport sink   (input valid, speed_forward, speed_strafe, speed_turn, output ready);
endinterface

// Wheel output channel
interface mwm_res_if;
  logic                          valid;
  logic                          ready;
  logic                          dir_front_left;
  logic [mwm_pkg::PULSE_W-1:0]   pulse_front_left;
  logic                          dir_front_right;
  logic [mwm_pkg::PULSE_W-1:0]   pulse_front_right;
  logic                          dir_rear_left;
  logic [mwm_pkg::PULSE_W-1:0]   pulse_rear_left;
  logic                          dir_rear_right;
  logic [mwm_pkg::PULSE_W-1:0]   pulse_rear_right;

  modport source (output valid, dir_front_left, pulse_front_left, dir_front_right,
                  pulse_front_right, dir_rear_left, pulse_rear_left, dir_rear_right,
                  pulse_rear_right, input ready);
  modport sink   (input valid, dir_front_left, pulse_front_left, dir_front_right,
                  pulse_front_right, dir_rear_left, pulse_rear_left, dir_rear_right,
                  pulse_rear_right, output ready);
endinterface

// ===== rtl/core/mwm_cfg.sv =====
module mwm_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mwm_pkg::ADDR_W-1:0]   paddr,
  input  logic [mwm_pkg::DATA_W-1:0]   pwdata,
  output logic [mwm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output mwm_pkg::cfg_t                cfg
);

  logic [mwm_pkg::PER_W-1:0] period_r;
  logic [mwm_pkg::MSK_W-1:0] invert_r;
  logic [0:0]                reg_idx;
  logic                      wr_en;

  // Registers are 4 bytes apart; low address bits are ignored
  assign reg_idx = paddr[mwm_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= mwm_pkg::PERIOD_RST;
      invert_r <= mwm_pkg::INVERT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        mwm_pkg::REG_PWM_PERIOD:  period_r <= pwdata[mwm_pkg::PER_W-1:0];
        mwm_pkg::REG_INVERT_MASK: invert_r <= pwdata[mwm_pkg::MSK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      mwm_pkg::REG_PWM_PERIOD:  prdata = mwm_pkg::DATA_W'(period_r);
      mwm_pkg::REG_INVERT_MASK: prdata = mwm_pkg::DATA_W'(invert_r);
      default:                  prdata = '0;
    endcase
  end

  assign cfg.period = period_r;
  assign cfg.invert = invert_r;

endmodule

// ===== rtl/core/mwm_mix.sv =====
module mwm_mix (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  output logic                              in_rdy,
  input  logic signed [mwm_pkg::SPD_W-1:0]  spd_fwd,
  input  logic signed [mwm_pkg::SPD_W-1:0]  spd_str,
  input  logic signed [mwm_pkg::SPD_W-1:0]  spd_trn,
  output logic                              out_vld,
  input  logic                              out_rdy,
  output mwm_pkg::div_t                     out_data
);

  logic                              a_vld_r;
  logic                              a_rdy;
  mwm_pkg::whl_vec_t                 a_whl_r;
  mwm_pkg::whl_vec_t                 a_whl_nxt;
  logic                              b_vld_r;
  logic                              b_rdy;
  mwm_pkg::div_t                     b_dat_r;
  mwm_pkg::div_t                     b_dat_nxt;
  logic signed [mwm_pkg::WHL_W-1:0]  fs;
  logic signed [mwm_pkg::WHL_W-1:0]  ss;
  logic signed [mwm_pkg::WHL_W-1:0]  ts;
  logic signed [mwm_pkg::WHL_W-1:0]  w [mwm_pkg::WHEELS];
  logic [mwm_pkg::MAG_W-1:0]         m01;
  logic [mwm_pkg::MAG_W-1:0]         m23;
  logic [mwm_pkg::MAG_W-1:0]         mx;

  assign b_rdy  = !b_vld_r || out_rdy;
  assign a_rdy  = !a_vld_r || b_rdy;
  assign in_rdy = a_rdy;

  // Stage A: saturate and mix into four wheel speeds
  always_comb begin
    fs = mwm_pkg::sat_pct(spd_fwd);
    ss = mwm_pkg::sat_pct(spd_str);
    ts = mwm_pkg::sat_pct(spd_trn);
    w[mwm_pkg::WHL_FL] = fs - ss - ts;
    w[mwm_pkg::WHL_FR] = fs + ss + ts;
    w[mwm_pkg::WHL_RL] = fs + ss - ts;
    w[mwm_pkg::WHL_RR] = fs - ss + ts;
    for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
      a_whl_nxt[i].neg = w[i][mwm_pkg::WHL_W-1];
      a_whl_nxt[i].mag = w[i][mwm_pkg::WHL_W-1] ? mwm_pkg::MAG_W'(-w[i])
                                                 : mwm_pkg::MAG_W'(w[i]);
    end
  end

  // Stage B: divisor is the largest magnitude, at least full scale; numerators mag*100
  always_comb begin
    m01 = (a_whl_r[0].mag > a_whl_r[1].mag) ? a_whl_r[0].mag : a_whl_r[1].mag;
    m23 = (a_whl_r[2].mag > a_whl_r[3].mag) ? a_whl_r[2].mag : a_whl_r[3].mag;
    mx  = (m01 > m23) ? m01 : m23;
    b_dat_nxt.den = (mx > mwm_pkg::MAG_W'(mwm_pkg::FULL_SCALE)) ? mx
                  : mwm_pkg::MAG_W'(mwm_pkg::FULL_SCALE);
    for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
      b_dat_nxt.w[i].neg = a_whl_r[i].neg;
      b_dat_nxt.w[i].rem = mwm_pkg::NUM_W'(a_whl_r[i].mag)
                         * mwm_pkg::NUM_W'(mwm_pkg::FULL_SCALE);
      b_dat_nxt.w[i].quo = '0;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) a_vld_r <= in_vld;
      if (b_rdy) b_vld_r <= a_vld_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (a_rdy && in_vld) a_whl_r <= a_whl_nxt;
    if (b_rdy && a_vld_r) b_dat_r <= b_dat_nxt;
  end

  assign out_vld  = b_vld_r;
  assign out_data = b_dat_r;

endmodule

// ===== rtl/core/mwm_div.sv =====
module mwm_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  output logic           in_rdy,
  input  mwm_pkg::div_t  in_data,
  output logic           out_vld,
  input  logic           out_rdy,
  output mwm_pkg::div_t  out_data
);

  localparam int unsigned STAGES = mwm_pkg::QUO_W;
  localparam int unsigned QIX_W  = $clog2(mwm_pkg::QUO_W);
  localparam int unsigned TRL_W  = mwm_pkg::NUM_W + 1;

  logic [STAGES-1:0]  vld_r;
  logic [STAGES-1:0]  vld_in;
  logic [STAGES-1:0]  rdy;
  mwm_pkg::div_t      dat_r   [STAGES];
  mwm_pkg::div_t      stg_in  [STAGES];
  mwm_pkg::div_t      stg_nxt [STAGES];
  logic               down_rdy;

  // One restoring step: try den << b against every wheel's remainder
  function automatic mwm_pkg::div_t div_step(input mwm_pkg::div_t d, input logic [QIX_W-1:0] b);
    mwm_pkg::div_t     r;
    logic [TRL_W-1:0]  trial;
    r = d;
    trial = TRL_W'(d.den) << b;
    for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
      if ({1'b0, d.w[i].rem} >= trial) begin
        r.w[i].rem    = d.w[i].rem - trial[mwm_pkg::NUM_W-1:0];
        r.w[i].quo[b] = 1'b1;
      end
    end
    return r;
  endfunction

  // Ready ripples back from the output; each stage takes one quotient bit, MSB first
  always_comb begin
    down_rdy = out_rdy;
    for (int g = STAGES - 1; g >= 0; g--) begin
      rdy[g]   = !vld_r[g] || down_rdy;
      down_rdy = rdy[g];
    end
    stg_in[0] = in_data;
    vld_in[0] = in_vld;
    for (int g = 1; g < STAGES; g++) begin
      stg_in[g] = dat_r[g-1];
      vld_in[g] = vld_r[g-1];
    end
    for (int g = 0; g < STAGES; g++) begin
      stg_nxt[g] = div_step(stg_in[g], QIX_W'(STAGES - 1 - g));
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int g = 0; g < STAGES; g++) begin
        if (rdy[g]) vld_r[g] <= vld_in[g];
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    for (int g = 0; g < STAGES; g++) begin
      if (rdy[g] && vld_in[g]) dat_r[g] <= stg_nxt[g];
    end
  end

  assign in_rdy   = rdy[0];
  assign out_vld  = vld_r[STAGES-1];
  assign out_data = dat_r[STAGES-1];

endmodule

// ===== rtl/core/mwm_pulse.sv =====
module mwm_pulse #(
  parameter int unsigned PULSE_BITS = mwm_pkg::PULSE_BITS_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  mwm_pkg::cfg_t                                      cfg,
  input  logic                                               in_vld,
  output logic                                               in_rdy,
  input  mwm_pkg::div_t                                      in_data,
  output logic                                               out_vld,
  input  logic                                               out_rdy,
  output logic [mwm_pkg::WHEELS-1:0]                         out_dir,
  output logic [mwm_pkg::WHEELS-1:0][mwm_pkg::PULSE_W-1:0]   out_pul
);

  // Pulse saturates to PULSE_BITS, never beyond the field width
  localparam int unsigned SAT_W = (PULSE_BITS < mwm_pkg::PULSE_W) ? PULSE_BITS
                                                                   : mwm_pkg::PULSE_W;
  localparam logic [mwm_pkg::PULSE_W-1:0] PULSE_LIM =
      mwm_pkg::PULSE_W'((64'd1 << SAT_W) - 64'd1);

  logic                                                   p1_vld_r;
  logic                                                   p1_rdy;
  logic [mwm_pkg::WHEELS-1:0]                             p1_fwd_r;
  logic [mwm_pkg::WHEELS-1:0]                             p1_fwd_nxt;
  logic [mwm_pkg::WHEELS-1:0][mwm_pkg::PROD_W-1:0]        p1_prod_r;
  logic [mwm_pkg::WHEELS-1:0][mwm_pkg::PROD_W-1:0]        p1_prod_nxt;
  logic                                                   p2_vld_r;
  logic                                                   p2_rdy;
  logic [mwm_pkg::WHEELS-1:0]                             p2_fwd_r;
  logic [mwm_pkg::WHEELS-1:0][mwm_pkg::PH_W-1:0]          p2_ph_r;
  logic [mwm_pkg::WHEELS-1:0][mwm_pkg::PH_W-1:0]          p2_ph_nxt;
  logic [mwm_pkg::WHEELS-1:0][mwm_pkg::PL_W-1:0]          p2_pl_r;
  logic [mwm_pkg::WHEELS-1:0][mwm_pkg::PL_W-1:0]          p2_pl_nxt;
  logic                                                   p3_vld_r;
  logic                                                   p3_rdy;
  logic [mwm_pkg::WHEELS-1:0]                             p3_dir_r;
  logic [mwm_pkg::WHEELS-1:0][mwm_pkg::PULSE_W-1:0]       p3_pul_r;
  logic [mwm_pkg::WHEELS-1:0][mwm_pkg::PULSE_W-1:0]       p3_pul_nxt;
  logic [mwm_pkg::Y_W-1:0]                                y;
  logic [mwm_pkg::SUM_W-1:0]                              sum;
  logic [mwm_pkg::PULSE_W-1:0]                            raw;

  assign p3_rdy = !p3_vld_r || out_rdy;
  assign p2_rdy = !p2_vld_r || p3_rdy;
  assign p1_rdy = !p1_vld_r || p2_rdy;
  assign in_rdy = p1_rdy;

  // P1: direction bit and period * scaled magnitude
  always_comb begin
    for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
      p1_fwd_nxt[i]  = (!in_data.w[i].neg || (in_data.w[i].quo == '0)) ^ cfg.invert[i];
      p1_prod_nxt[i] = mwm_pkg::PROD_W'(cfg.period) * mwm_pkg::PROD_W'(in_data.w[i].quo);
    end
  end

  // P2: reciprocal multiply of (product / 4), split in two partial products
  always_comb begin
    y = '0;
    for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
      y            = p1_prod_r[i][mwm_pkg::PROD_W-1:2];
      p2_ph_nxt[i] = mwm_pkg::PH_W'(y[mwm_pkg::Y_W-1:mwm_pkg::YL_W])
                   * mwm_pkg::PH_W'(mwm_pkg::RECIP_25);
      p2_pl_nxt[i] = mwm_pkg::PL_W'(y[mwm_pkg::YL_W-1:0])
                   * mwm_pkg::PL_W'(mwm_pkg::RECIP_25);
    end
  end

  // P3: combine partials, take the quotient, saturate
  always_comb begin
    sum = '0;
    raw = '0;
    for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
      sum = (mwm_pkg::SUM_W'(p2_ph_r[i]) << mwm_pkg::YL_W) + mwm_pkg::SUM_W'(p2_pl_r[i]);
      raw = sum[mwm_pkg::RECIP_SHIFT +: mwm_pkg::PULSE_W];
      p3_pul_nxt[i] = (raw > PULSE_LIM) ? PULSE_LIM : raw;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else begin
      if (p1_rdy) p1_vld_r <= in_vld;
      if (p2_rdy) p2_vld_r <= p1_vld_r;
      if (p3_rdy) p3_vld_r <= p2_vld_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (p1_rdy && in_vld) begin
      p1_fwd_r  <= p1_fwd_nxt;
      p1_prod_r <= p1_prod_nxt;
    end
    if (p2_rdy && p1_vld_r) begin
      p2_fwd_r <= p1_fwd_r;
      p2_ph_r  <= p2_ph_nxt;
      p2_pl_r  <= p2_pl_nxt;
    end
    if (p3_rdy && p2_vld_r) begin
      p3_dir_r <= p2_fwd_r;
      p3_pul_r <= p3_pul_nxt;
    end
  end

  assign out_vld = p3_vld_r;
  assign out_dir = p3_dir_r;
  assign out_pul = p3_pul_r;

endmodule

// ===== rtl/core/mecanum_wheel_mixer_pwm_top.sv =====
// Channel   | Dir | Handshake            | Carries
// in_cmd    | in  | valid/ready          | speed_forward, speed_strafe, speed_turn
// out_res   | out | valid/ready          | dir and pulse width for FL, FR, RL, RR
// config    | in  | APB psel/penable     | pwm_period at 0x0, invert_mask at 0x4
//
// One command per cycle unless out_res stalls; 2 mix stages, 7 divider stages
// (one quotient bit each, set by the 100..300 divisor), 3 pulse stages.
// Synchronous active-low reset clears the stage valid bits and loads the
// register defaults (period 20000, invert mask 5).
// Each stage holds while the stage after it is full and stalled; bubbles
// close up, so in_cmd.ready drops only when all 12 stages hold a request.
module mecanum_wheel_mixer_pwm_top #(
  parameter int unsigned PULSE_BITS = mwm_pkg::PULSE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  mwm_cmd_if.sink                      in_cmd,
  mwm_res_if.source                    out_res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mwm_pkg::ADDR_W-1:0]   paddr,
  input  logic [mwm_pkg::DATA_W-1:0]   pwdata,
  output logic [mwm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  mwm_pkg::cfg_t                                          cfg;
  logic                                                   mix_vld;
  logic                                                   mix_rdy;
  mwm_pkg::div_t                                          mix_data;
  logic                                                   div_vld;
  logic                                                   div_rdy;
  mwm_pkg::div_t                                          div_data;
  logic [mwm_pkg::WHEELS-1:0]                             res_dir;
  logic [mwm_pkg::WHEELS-1:0][mwm_pkg::PULSE_W-1:0]       res_pul;

  // Register file
  mwm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Saturate, mix, find the divisor
  mwm_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_cmd.valid),
    .in_rdy   (in_cmd.ready),
    .spd_fwd  (in_cmd.speed_forward),
    .spd_str  (in_cmd.speed_strafe),
    .spd_trn  (in_cmd.speed_turn),
    .out_vld  (mix_vld),
    .out_rdy  (mix_rdy),
    .out_data (mix_data)
  );

  // mag*100 / maxmag for all four wheels
  mwm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (mix_vld),
    .in_rdy   (mix_rdy),
    .in_data  (mix_data),
    .out_vld  (div_vld),
    .out_rdy  (div_rdy),
    .out_data (div_data)
  );

  // Direction bits and pulse widths
  mwm_pulse #(
    .PULSE_BITS (PULSE_BITS)
  ) u_pulse (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_vld  (div_vld),
    .in_rdy  (div_rdy),
    .in_data (div_data),
    .out_vld (out_res.valid),
    .out_rdy (out_res.ready),
    .out_dir (res_dir),
    .out_pul (res_pul)
  );

  assign out_res.dir_front_left    = res_dir[mwm_pkg::WHL_FL];
  assign out_res.pulse_front_left  = res_pul[mwm_pkg::WHL_FL];
  assign out_res.dir_front_right   = res_dir[mwm_pkg::WHL_FR];
  assign out_res.pulse_front_right = res_pul[mwm_pkg::WHL_FR];
  assign out_res.dir_rear_left     = res_dir[mwm_pkg::WHL_RL];
  assign out_res.pulse_rear_left   = res_pul[mwm_pkg::WHL_RL];
  assign out_res.dir_rear_right    = res_dir[mwm_pkg::WHL_RR];
  assign out_res.pulse_rear_right  = res_pul[mwm_pkg::WHL_RR];

`ifndef SYNTHESIS
  // Nothing comes out the cycle after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_res.valid)
    else $error("result valid right after reset");

  // Input backs up only when the pipe is full behind a stalled result
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_cmd.ready |-> (out_res.valid && !out_res.ready))
    else $error("input stalled while result side is free");

  // A period write reads back on the next cycle
  a_period_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && (paddr[mwm_pkg::ADDR_W-1] == mwm_pkg::REG_PWM_PERIOD))
    ##1 (paddr[mwm_pkg::ADDR_W-1] == mwm_pkg::REG_PWM_PERIOD)
    |-> (prdata[mwm_pkg::PER_W-1:0] == $past(pwdata[mwm_pkg::PER_W-1:0])))
    else $error("period readback mismatch");
`endif

endmodule

// ===== tb/tb_mecanum_wheel_mixer_pwm_top.sv =====
module tb_mecanum_wheel_mixer_pwm_top;
  import mwm_pkg::*;

  // Expected wheel outputs for one drive request
  typedef struct packed {
    logic               dir_fl;
    logic [PULSE_W-1:0] pulse_fl;
    logic               dir_fr;
    logic [PULSE_W-1:0] pulse_fr;
    logic               dir_rl;
    logic [PULSE_W-1:0] pulse_rl;
    logic               dir_rr;
    logic [PULSE_W-1:0] pulse_rr;
  } wheels_t;

  // One directed drive request; res is only used when typed is set
  typedef struct packed {
    logic signed [SPD_W-1:0] fwd;
    logic signed [SPD_W-1:0] strafe;
    logic signed [SPD_W-1:0] turn;
    logic                    typed;
    wheels_t                 res;
  } cmd_row_t;

  localparam longint PULSE_MAX   = (64'd1 << PULSE_BITS_DEF) - 1;
  localparam int     N_DIRECTED  = 23;
  localparam int     N_PHASES    = 5;
  localparam int     PHASE_ITEMS = 215;

  // Outputs at reset config (period 20000, invert FL and RL)
  localparam wheels_t STOPPED  = '{1'b0, 16'd0, 1'b1, 16'd0, 1'b0, 16'd0, 1'b1, 16'd0};
  localparam wheels_t FWD_FULL = '{1'b0, PERIOD_RST, 1'b1, PERIOD_RST,
                                   1'b0, PERIOD_RST, 1'b1, PERIOD_RST};
  localparam wheels_t REV_FULL = '{1'b1, PERIOD_RST, 1'b0, PERIOD_RST,
                                   1'b1, PERIOD_RST, 1'b0, PERIOD_RST};
  localparam wheels_t STRAFE_L = '{1'b1, PERIOD_RST, 1'b1, PERIOD_RST,
                                   1'b0, PERIOD_RST, 1'b0, PERIOD_RST};
  localparam wheels_t STRAFE_R = '{1'b0, PERIOD_RST, 1'b0, PERIOD_RST,
                                   1'b1, PERIOD_RST, 1'b1, PERIOD_RST};
  localparam wheels_t TURN_CCW = '{1'b1, PERIOD_RST, 1'b1, PERIOD_RST,
                                   1'b1, PERIOD_RST, 1'b1, PERIOD_RST};
  localparam wheels_t TURN_CW  = '{1'b0, PERIOD_RST, 1'b0, PERIOD_RST,
                                   1'b0, PERIOD_RST, 1'b0, PERIOD_RST};

  cmd_row_t directed_rows [N_DIRECTED] = '{
    '{8'sd0,    8'sd0,    8'sd0,    1'b1, STOPPED},
    '{8'sd100,  8'sd0,    8'sd0,    1'b1, FWD_FULL},
    '{-8'sd100, 8'sd0,    8'sd0,    1'b1, REV_FULL},
    '{8'sh7F,   8'sd0,    8'sd0,    1'b1, FWD_FULL},   // clamps to +100
    '{8'sh80,   8'sd0,    8'sd0,    1'b1, REV_FULL},   // clamps to -100
    '{8'sd0,    8'sd100,  8'sd0,    1'b1, STRAFE_L},
    '{8'sd0,    -8'sd100, 8'sd0,    1'b1, STRAFE_R},
    '{8'sd0,    8'sd0,    8'sd100,  1'b1, TURN_CCW},
    '{8'sd0,    8'sd0,    -8'sd100, 1'b1, TURN_CW},
    '{8'sd0,    8'sh7F,   8'sd0,    1'b0, '0},
    '{8'sd0,    8'sh80,   8'sd0,    1'b0, '0},
    '{8'sd0,    8'sd0,    8'sh7F,   1'b0, '0},
    '{8'sd0,    8'sd0,    8'sh80,   1'b0, '0},
    '{8'sd100,  8'sd100,  8'sd100,  1'b0, '0},
    '{-8'sd100, -8'sd100, -8'sd100, 1'b0, '0},
    '{8'sh7F,   8'sh7F,   8'sh7F,   1'b0, '0},
    '{8'sh80,   8'sh80,   8'sh80,   1'b0, '0},
    '{8'sd100,  -8'sd100, 8'sd100,  1'b0, '0},
    '{8'sd100,  8'sd100,  -8'sd1,   1'b0, '0},   // RR scales to zero from -1
    '{-8'sd100, -8'sd100, 8'sd1,    1'b0, '0},   // FL scales to zero from -1
    '{8'sd1,    8'sd0,    8'sd0,    1'b0, '0},
    '{-8'sd101, 8'sd101,  -8'sd101, 1'b0, '0},
    '{8'sd50,   -8'sd30,  8'sd20,   1'b0, '0}
  };

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  mwm_cmd_if cmd_if ();
  mwm_res_if res_if ();

  mecanum_wheel_mixer_pwm_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (cmd_if),
    .out_res (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the config registers and the pending wheel outputs
  logic [PER_W-1:0] period_reg;
  logic [MSK_W-1:0] invert_reg;
  wheels_t          wheel_q [$];
  int               mismatch_cnt = 0;
  bit               quiet_tail;
  bit               tx_calm;
  int               tx_calm_left = 0;
  wheels_t          want_w;
  wheels_t          seen_w;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #4_000_000;
    $display("tb_mecanum_wheel_mixer_pwm_top: FAIL");
    $finish;
  end

  function automatic int clamp_pct(input logic signed [SPD_W-1:0] v);
    int x;
    x = v;
    if (x > int'(FULL_SCALE)) return FULL_SCALE;
    if (x < -int'(FULL_SCALE)) return -int'(FULL_SCALE);
    return x;
  endfunction

  // Mix a drive request into four wheels, normalize, then direction and pulse width
  function automatic wheels_t mix_wheels(input logic signed [SPD_W-1:0] f_in,
                                         input logic signed [SPD_W-1:0] s_in,
                                         input logic signed [SPD_W-1:0] t_in);
    int               f, s, t, maxmag, mag;
    int               w [WHEELS];
    logic             dir [WHEELS];
    logic [PULSE_W-1:0] pw [WHEELS];
    longint           pulse;
    logic             fwd;
    wheels_t          r;
    f = clamp_pct(f_in);
    s = clamp_pct(s_in);
    t = clamp_pct(t_in);
    w[WHL_FL] = f - s - t;
    w[WHL_FR] = f + s + t;
    w[WHL_RL] = f + s - t;
    w[WHL_RR] = f - s + t;
    maxmag = FULL_SCALE;
    for (int i = 0; i < WHEELS; i++) begin
      if ((w[i] < 0 ? -w[i] : w[i]) > maxmag) maxmag = (w[i] < 0 ? -w[i] : w[i]);
    end
    for (int i = 0; i < WHEELS; i++) begin
      mag = ((w[i] < 0 ? -w[i] : w[i]) * int'(FULL_SCALE)) / maxmag;
      // a speed that truncates to zero counts as forward
      fwd = (w[i] >= 0) || (mag == 0);
      if (mag > int'(FULL_SCALE)) mag = FULL_SCALE;
      if (invert_reg[i]) fwd = ~fwd;
      pulse = (longint'(period_reg) * mag) / int'(FULL_SCALE);
      if (pulse > PULSE_MAX) pulse = PULSE_MAX;
      dir[i] = fwd;
      pw[i]  = pulse[PULSE_W-1:0];
    end
    r.dir_fl = dir[WHL_FL];  r.pulse_fl = pw[WHL_FL];
    r.dir_fr = dir[WHL_FR];  r.pulse_fr = pw[WHL_FR];
    r.dir_rl = dir[WHL_RL];  r.pulse_rl = pw[WHL_RL];
    r.dir_rr = dir[WHL_RR];  r.pulse_rr = pw[WHL_RR];
    return r;
  endfunction

  // Mostly in range, some out-of-range bytes and edge values
  function automatic logic signed [SPD_W-1:0] rand_speed();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return SPD_W'($urandom_range(0, 255));
    if (pick == 1) begin
      case ($urandom_range(0, 8))
        0: return 8'sh80;
        1: return -8'sd101;
        2: return -8'sd100;
        3: return -8'sd1;
        4: return 8'sd0;
        5: return 8'sd1;
        6: return 8'sd100;
        7: return 8'sd101;
        default: return 8'sh7F;
      endcase
    end
    return SPD_W'(int'($urandom_range(0, 200)) - 100);
  endfunction

  // Sender idle gap, with calm stretches and none in the tail
  function automatic int pick_gap();
    if (tx_calm_left == 0) begin
      tx_calm      = ($urandom_range(0, 3) == 0);
      tx_calm_left = $urandom_range(20, 60);
    end
    tx_calm_left--;
    if (quiet_tail || tx_calm || $urandom_range(0, 5) != 0) return 0;
    return $urandom_range(1, 15);
  endfunction

  function automatic void check_field(input string name, input logic [PULSE_W-1:0] want,
                                      input logic [PULSE_W-1:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
      mismatch_cnt++;
    end
  endfunction

  // Send one drive request and queue its expected wheel outputs on acceptance
  task automatic drive_cmd(input logic signed [SPD_W-1:0] f, input logic signed [SPD_W-1:0] s,
                           input logic signed [SPD_W-1:0] t, input logic typed,
                           input wheels_t typed_res, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    cmd_if.valid         <= 1'b1;
    cmd_if.speed_forward <= f;
    cmd_if.speed_strafe  <= s;
    cmd_if.speed_turn    <= t;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    wheel_q.push_back(typed ? typed_res : mix_wheels(f, s, t));
  endtask

  // Drop valid and wait until every queued request has come out
  task automatic settle();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (wheel_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [0:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_PWM_PERIOD) period_reg = data[PER_W-1:0];
    else invert_reg = data[MSK_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result sink: random stall bursts, calm stretches, none in the tail
  initial begin
    int stall_left;
    int calm_left;
    bit calm;
    stall_left   = 0;
    calm_left    = 0;
    calm         = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 2) == 0);
        calm_left = $urandom_range(50, 200);
      end
      calm_left--;
      if (stall_left == 0 && !quiet_tail && !calm && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 15);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      seen_w.dir_fl   = res_if.dir_front_left;
      seen_w.pulse_fl = res_if.pulse_front_left;
      seen_w.dir_fr   = res_if.dir_front_right;
      seen_w.pulse_fr = res_if.pulse_front_right;
      seen_w.dir_rl   = res_if.dir_rear_left;
      seen_w.pulse_rl = res_if.pulse_rear_left;
      seen_w.dir_rr   = res_if.dir_rear_right;
      seen_w.pulse_rr = res_if.pulse_rear_right;
      if (wheel_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, seen_w);
        mismatch_cnt++;
      end else begin
        want_w = wheel_q.pop_front();
        check_field("dir_front_left",    PULSE_W'(want_w.dir_fl), PULSE_W'(seen_w.dir_fl));
        check_field("pulse_front_left",  want_w.pulse_fl, seen_w.pulse_fl);
        check_field("dir_front_right",   PULSE_W'(want_w.dir_fr), PULSE_W'(seen_w.dir_fr));
        check_field("pulse_front_right", want_w.pulse_fr, seen_w.pulse_fr);
        check_field("dir_rear_left",     PULSE_W'(want_w.dir_rl), PULSE_W'(seen_w.dir_rl));
        check_field("pulse_rear_left",   want_w.pulse_rl, seen_w.pulse_rl);
        check_field("dir_rear_right",    PULSE_W'(want_w.dir_rr), PULSE_W'(seen_w.dir_rr));
        check_field("pulse_rear_right",  want_w.pulse_rr, seen_w.pulse_rr);
      end
    end
  end

  // Main sequence: reset, directed table, then random phases over several configs
  initial begin
    logic [PER_W-1:0] per;
    logic [MSK_W-1:0] msk;
    rst_n                = 1'b0;
    cmd_if.valid         = 1'b0;
    cmd_if.speed_forward = '0;
    cmd_if.speed_strafe  = '0;
    cmd_if.speed_turn    = '0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    period_reg           = PERIOD_RST;
    invert_reg           = INVERT_RST;
    quiet_tail           = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows run at the reset config
    for (int i = 0; i < N_DIRECTED; i++) begin
      drive_cmd(directed_rows[i].fwd, directed_rows[i].strafe, directed_rows[i].turn,
                directed_rows[i].typed, directed_rows[i].res, pick_gap());
    end
    settle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin per = 16'hFFFF; msk = 4'hF; end
        1: begin per = 16'd1;    msk = 4'h0; end
        2: begin per = 16'd0;    msk = MSK_W'($urandom_range(0, 15)); end
        default: begin
          per = PER_W'($urandom_range(1, 65535));
          msk = MSK_W'($urandom_range(0, 15));
        end
      endcase
      // upper data bits are don't-care for both registers
      cfg_write(REG_PWM_PERIOD, {PER_W'($urandom), per});
      cfg_write(REG_INVERT_MASK, {28'($urandom), msk});
      if (ph == N_PHASES - 1) quiet_tail = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 1 && k == 100) settle();
        drive_cmd(rand_speed(), rand_speed(), rand_speed(), 1'b0, '0, pick_gap());
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb_mecanum_wheel_mixer_pwm_top: PASS");
    end else begin
      $display("tb_mecanum_wheel_mixer_pwm_top: FAIL");
    end
    $finish;
  end

endmodule
